@@ rtl/owr_pkg.sv @@
// ----------------------------------------------------------------------------
// owr_pkg
// Shared types, constants and helpers of the 1-wire temperature reader.
// ----------------------------------------------------------------------------
package owr_pkg;

  localparam int BITS_PER_BYTE   = 8;
  localparam int BIT_IDX_W       = 3;
  localparam int BYTE_IDX_W      = 3;
  localparam int TICK_W          = 20;
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 20;
  localparam int OWR_QUEUE_DEPTH = 2;

  localparam logic [7:0] CMD_SKIP_ROM     = 8'hCC;
  localparam logic [7:0] CMD_CONVERT      = 8'h44;
  localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

  localparam logic [9:0]  RST_RESET_LOW     = 10'd480;
  localparam logic [7:0]  RST_PRESENCE_WAIT = 8'd80;
  localparam logic [9:0]  RST_RESET_TAIL    = 10'd400;
  localparam logic [7:0]  RST_SLOT          = 8'd50;
  localparam logic [15:0] RST_CMD_GAP       = 16'd1000;
  localparam logic [19:0] RST_CONV_WAIT     = 20'd800000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESET_LOW     = 3'd0,
    REG_PRESENCE_WAIT = 3'd1,
    REG_RESET_TAIL    = 3'd2,
    REG_SLOT          = 3'd3,
    REG_CMD_GAP       = 3'd4,
    REG_CONV_WAIT     = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic start_req;
    logic line_in;
  } item_t;

  typedef struct packed {
    logic        drive_low;
    logic        busy_res;
    logic        done_res;
    logic        status;
    logic [15:0] temperature_raw;
  } result_t;

  typedef struct packed {
    logic [9:0]  reset_low_ticks;
    logic [7:0]  presence_wait_ticks;
    logic [9:0]  reset_tail_ticks;
    logic [7:0]  slot_ticks;
    logic [15:0] command_gap_ticks;
    logic [19:0] convert_wait_ticks;
  } cfg_t;

  // Command byte sequence: skip-ROM, convert, skip-ROM, read scratchpad.
  function automatic logic [7:0] cmd_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = CMD_SKIP_ROM;
      2'd1:    b = CMD_CONVERT;
      2'd2:    b = CMD_SKIP_ROM;
      default: b = CMD_READ_SCRATCH;
    endcase
    return b;
  endfunction

endpackage

@@ rtl/owr_if.sv @@
// ----------------------------------------------------------------------------
// owr_if
// Channel interfaces of the 1-wire temperature reader.
// ----------------------------------------------------------------------------
interface owr_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic line_in;

  modport source (output valid, output start_req, output line_in, input ready);
  modport sink   (input valid, input start_req, input line_in, output ready);
endinterface

interface owr_out_if;
  logic        valid;
  logic        ready;
  logic        drive_low;
  logic        busy_res;
  logic        done_res;
  logic        status;
  logic [15:0] temperature_raw;

  modport source (output valid, output drive_low, output busy_res, output done_res,
                  output status, output temperature_raw, input ready);
  modport sink   (input valid, input drive_low, input busy_res, input done_res,
                  input status, input temperature_raw, output ready);
endinterface

interface owr_cfg_if import owr_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, output idx, output wdata, input ready);
  modport sink   (input valid, input idx, input wdata, output ready);
endinterface

@@ rtl/owr_cfg.sv @@
// ----------------------------------------------------------------------------
// owr_cfg
// Timing register file, written through the configuration channel.
// ----------------------------------------------------------------------------
module owr_cfg import owr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  owr_cfg_if.sink    cfg_ch,
  output cfg_t       cfg_o
);

  cfg_t cfg_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg_o        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reset_low_ticks     <= RST_RESET_LOW;
      cfg_r.presence_wait_ticks <= RST_PRESENCE_WAIT;
      cfg_r.reset_tail_ticks    <= RST_RESET_TAIL;
      cfg_r.slot_ticks          <= RST_SLOT;
      cfg_r.command_gap_ticks   <= RST_CMD_GAP;
      cfg_r.convert_wait_ticks  <= RST_CONV_WAIT;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      unique case (cfg_ch.idx)
        REG_RESET_LOW:     cfg_r.reset_low_ticks     <= cfg_ch.wdata[9:0];
        REG_PRESENCE_WAIT: cfg_r.presence_wait_ticks <= cfg_ch.wdata[7:0];
        REG_RESET_TAIL:    cfg_r.reset_tail_ticks    <= cfg_ch.wdata[9:0];
        REG_SLOT:          cfg_r.slot_ticks          <= cfg_ch.wdata[7:0];
        REG_CMD_GAP:       cfg_r.command_gap_ticks   <= cfg_ch.wdata[15:0];
        REG_CONV_WAIT:     cfg_r.convert_wait_ticks  <= cfg_ch.wdata[19:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/owr_front.sv @@
// ----------------------------------------------------------------------------
// owr_front
// Accepts tick transactions and holds them in a short queue for the engine.
// ----------------------------------------------------------------------------
module owr_front import owr_pkg::*; #(
  parameter int DEPTH = OWR_QUEUE_DEPTH
) (
  input  logic    clk,
  input  logic    rst_n,
  owr_in_if.sink  in_ch,
  output item_t   q_item,
  output logic    q_valid,
  input  logic    q_pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  item_t            mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             push;
  item_t            in_item;

  assign in_item.start_req = in_ch.start_req;
  assign in_item.line_in   = in_ch.line_in;

  assign in_ch.ready = (count_r != CNT_W'(DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != '0);
  assign q_item      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (q_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !q_pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && q_pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

@@ rtl/owr_back.sv @@
// ----------------------------------------------------------------------------
// owr_back
// Bus sequencer: runs one tick per transaction and registers the result.
// ----------------------------------------------------------------------------
module owr_back import owr_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_t      cfg_i,
  input  item_t     q_item,
  input  logic      q_valid,
  output logic      q_pop,
  owr_out_if.source out_ch
);

  typedef enum logic [3:0] {
    PH_IDLE, PH_RLOW, PH_RWAIT, PH_RTAIL, PH_GAP, PH_WRITE, PH_CONV, PH_READ
  } phase_t;

  phase_t                phase_r, phase_nxt, ph_cur;
  logic [TICK_W-1:0]     tick_r, tick_nxt, tick_cur;
  logic [BIT_IDX_W-1:0]  bit_r, bit_nxt, bit_cur;
  logic [BYTE_IDX_W-1:0] byte_r, byte_nxt, byte_cur, byte_inc;
  logic [7:0]            shift_r, shift_nxt, shift_cur;
  logic [7:0]            low_r, low_nxt;
  logic [15:0]           reading_r, reading_nxt;
  logic                  status_r, status_nxt;
  result_t               out_r, result;
  logic                  out_valid_r;

  logic [TICK_W:0]       tick_p1;
  logic [TICK_W:0]       low_lim, tail_lim, conv_lim;
  logic [7:0]            slot_lim;
  logic [7:0]            cmd;
  logic                  slot_end, bit_last, drv, done;

  assign q_pop = q_valid && (!out_valid_r || out_ch.ready);

  assign out_ch.valid           = out_valid_r;
  assign out_ch.drive_low       = out_r.drive_low;
  assign out_ch.busy_res        = out_r.busy_res;
  assign out_ch.done_res        = out_r.done_res;
  assign out_ch.status          = out_r.status;
  assign out_ch.temperature_raw = out_r.temperature_raw;

  assign low_lim  = (cfg_i.reset_low_ticks == '0) ? (TICK_W+1)'(1)
                                                  : (TICK_W+1)'(cfg_i.reset_low_ticks);
  assign tail_lim = (cfg_i.reset_tail_ticks == '0) ? (TICK_W+1)'(1)
                                                   : (TICK_W+1)'(cfg_i.reset_tail_ticks);
  assign conv_lim = (cfg_i.convert_wait_ticks == '0) ? (TICK_W+1)'(1)
                                                     : (TICK_W+1)'(cfg_i.convert_wait_ticks);
  assign slot_lim = (cfg_i.slot_ticks < 8'd2) ? 8'd2 : cfg_i.slot_ticks;

  always_comb begin
    ph_cur    = phase_r;
    tick_cur  = tick_r;
    bit_cur   = bit_r;
    byte_cur  = byte_r;
    shift_cur = shift_r;
    if (phase_r == PH_IDLE && q_item.start_req) begin
      ph_cur    = PH_RLOW;
      tick_cur  = '0;
      bit_cur   = '0;
      byte_cur  = '0;
      shift_cur = '0;
    end

    tick_p1  = {1'b0, tick_cur} + (TICK_W+1)'(1);
    slot_end = (tick_cur >= TICK_W'(slot_lim));
    bit_last = (bit_cur == BIT_IDX_W'(BITS_PER_BYTE - 1));
    byte_inc = byte_cur + 1'b1;
    cmd      = cmd_byte(byte_cur[1:0]);

    phase_nxt   = ph_cur;
    tick_nxt    = tick_cur;
    bit_nxt     = bit_cur;
    byte_nxt    = byte_cur;
    shift_nxt   = shift_cur;
    low_nxt     = low_r;
    reading_nxt = reading_r;
    status_nxt  = status_r;
    drv         = 1'b0;
    done        = 1'b0;

    unique case (ph_cur)
      PH_IDLE: ;
      PH_RLOW: begin
        drv = 1'b1;
        if (tick_p1 >= low_lim) begin
          phase_nxt = PH_RWAIT;
          tick_nxt  = '0;
        end else begin
          tick_nxt = tick_p1[TICK_W-1:0];
        end
      end
      PH_RWAIT: begin
        if (tick_cur >= TICK_W'(cfg_i.presence_wait_ticks)) begin
          status_nxt = q_item.line_in;
          phase_nxt  = PH_RTAIL;
          tick_nxt   = '0;
        end else begin
          tick_nxt = tick_p1[TICK_W-1:0];
        end
      end
      PH_RTAIL: begin
        if (tick_p1 >= tail_lim) begin
          tick_nxt = '0;
          bit_nxt  = '0;
          if (status_r) begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end else begin
            phase_nxt = (cfg_i.command_gap_ticks == '0) ? PH_WRITE : PH_GAP;
          end
        end else begin
          tick_nxt = tick_p1[TICK_W-1:0];
        end
      end
      PH_GAP: begin
        if (tick_p1 >= (TICK_W+1)'(cfg_i.command_gap_ticks)) begin
          phase_nxt = PH_WRITE;
          tick_nxt  = '0;
          bit_nxt   = '0;
        end else begin
          tick_nxt = tick_p1[TICK_W-1:0];
        end
      end
      PH_WRITE: begin
        if (!slot_end) begin
          drv = cmd[bit_cur] ? (tick_cur == '0) : 1'b1;
        end
        if (slot_end) begin
          tick_nxt = '0;
          if (bit_last) begin
            bit_nxt  = '0;
            byte_nxt = byte_inc;
            if (byte_inc == BYTE_IDX_W'(2)) begin
              phase_nxt = PH_CONV;
            end else if (byte_inc >= BYTE_IDX_W'(4)) begin
              phase_nxt = PH_READ;
            end
          end else begin
            bit_nxt = bit_cur + 1'b1;
          end
        end else begin
          tick_nxt = tick_p1[TICK_W-1:0];
        end
      end
      PH_CONV: begin
        if (tick_p1 >= conv_lim) begin
          phase_nxt = PH_RLOW;
          tick_nxt  = '0;
        end else begin
          tick_nxt = tick_p1[TICK_W-1:0];
        end
      end
      PH_READ: begin
        drv = (tick_cur == '0);
        if (tick_cur == TICK_W'(2)) begin
          shift_nxt = shift_cur | (8'(q_item.line_in) << bit_cur);
        end
        if (slot_end) begin
          tick_nxt = '0;
          if (bit_last) begin
            bit_nxt = '0;
            if (byte_cur == BYTE_IDX_W'(4)) begin
              low_nxt   = shift_nxt;
              shift_nxt = '0;
              byte_nxt  = BYTE_IDX_W'(5);
            end else begin
              reading_nxt = {shift_nxt, low_r};
              status_nxt  = 1'b0;
              phase_nxt   = PH_IDLE;
              done        = 1'b1;
            end
          end else begin
            bit_nxt = bit_cur + 1'b1;
          end
        end else begin
          tick_nxt = tick_p1[TICK_W-1:0];
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
        tick_nxt  = '0;
      end
    endcase

    result.drive_low       = drv;
    result.busy_res        = (ph_cur != PH_IDLE);
    result.done_res        = done;
    result.status          = status_nxt;
    result.temperature_raw = reading_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      tick_r      <= '0;
      bit_r       <= '0;
      byte_r      <= '0;
      shift_r     <= '0;
      low_r       <= '0;
      reading_r   <= '0;
      status_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        phase_r     <= phase_nxt;
        tick_r      <= tick_nxt;
        bit_r       <= bit_nxt;
        byte_r      <= byte_nxt;
        shift_r     <= shift_nxt;
        low_r       <= low_nxt;
        reading_r   <= reading_nxt;
        status_r    <= status_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= result;
    end
  end

endmodule

@@ rtl/one_wire_temperature_reader.sv @@
// ----------------------------------------------------------------------------
// one_wire_temperature_reader
// 1-wire bus master that reads one raw temperature from a single-drop sensor.
//
//   Channel   Direction  Transaction carries
//   in_ch     sink       start_req, line_in (one microsecond tick)
//   out_ch    source     drive_low, busy_res, done_res, status, temperature_raw
//   cfg_ch    sink       idx, wdata (timing register write)
//
// One tick transaction is taken per clock cycle while the queue has room; it
// waits in a queue of QUEUE_DEPTH entries between the input and the sequencer,
// and its result sits in an output register, so either side can stall without
// holding up the other while there is room.
// Reset is synchronous and restores the default timing registers.
// ----------------------------------------------------------------------------
module one_wire_temperature_reader import owr_pkg::*; #(
  parameter int QUEUE_DEPTH = OWR_QUEUE_DEPTH
) (
  input  logic      clk,
  input  logic      rst_n,
  owr_in_if.sink    in_ch,
  owr_out_if.source out_ch,
  owr_cfg_if.sink   cfg_ch
);

  cfg_t  cfg;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  owr_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg_o  (cfg)
  );

  owr_front #(
    .DEPTH (QUEUE_DEPTH)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  owr_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg_i   (cfg),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .out_ch  (out_ch)
  );

endmodule

@@ tb/sv/one_wire_temperature_reader_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// one_wire_temperature_reader_tb
// Drives microsecond ticks into the 1-wire reader and checks every result
// transaction against a cycle-exact predictor of the bus sequencer. Directed
// runs cover zero, minimum and masked timing. Random runs then use short
// timings, random presence and random read bits, under changing stall patterns.
// ----------------------------------------------------------------------------
module one_wire_temperature_reader_tb;
  import owr_pkg::*;

  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned TOTAL_TICKS = 850;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

  typedef enum logic [3:0] {
    SEQ_IDLE,
    SEQ_RESET_LOW,
    SEQ_PRESENCE,
    SEQ_RESET_TAIL,
    SEQ_GAP,
    SEQ_WRITE,
    SEQ_CONVERT,
    SEQ_READ
  } seq_phase_t;

  typedef enum int {READ_RANDOM, READ_ZEROS, READ_ONES} read_pattern_t;

  class temp_read_scoreboard;
    logic [9:0]  reset_low;
    logic [7:0]  presence_wait;
    logic [9:0]  reset_tail;
    logic [7:0]  slot_len;
    logic [15:0] cmd_gap;
    logic [19:0] conv_wait;
    logic [7:0]  command_seq [4];
    seq_phase_t  phase;
    int unsigned ticks;
    logic [2:0]  bit_pos;
    logic [2:0]  byte_pos;
    logic [7:0]  shift_reg;
    logic [7:0]  lsb_byte;
    logic [15:0] reading;
    logic        last_status;
    result_t     expected_results[$];
    int unsigned errors;

    function new();
      reset_low     = RST_RESET_LOW;
      presence_wait = RST_PRESENCE_WAIT;
      reset_tail    = RST_RESET_TAIL;
      slot_len      = RST_SLOT;
      cmd_gap       = RST_CMD_GAP;
      conv_wait     = RST_CONV_WAIT;
      command_seq   = '{CMD_SKIP_ROM, CMD_CONVERT, CMD_SKIP_ROM, CMD_READ_SCRATCH};
      phase         = SEQ_IDLE;
      ticks         = 0;
      bit_pos       = '0;
      byte_pos      = '0;
      shift_reg     = '0;
      lsb_byte      = '0;
      reading       = '0;
      last_status   = 1'b0;
      errors        = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_RESET_LOW:     reset_low     = data[9:0];
        REG_PRESENCE_WAIT: presence_wait = data[7:0];
        REG_RESET_TAIL:    reset_tail    = data[9:0];
        REG_SLOT:          slot_len      = data[7:0];
        REG_CMD_GAP:       cmd_gap       = data[15:0];
        REG_CONV_WAIT:     conv_wait     = data[19:0];
        default: ;
      endcase
    endfunction

    function int unsigned at_least_one(int unsigned v);
      return (v == 0) ? 1 : v;
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction

    function void note_tick(item_t it);
      result_t     exp;
      int unsigned slot;
      logic [7:0]  cmd;
      slot = (slot_len < 2) ? 2 : slot_len;
      exp = '0;
      if (phase == SEQ_IDLE && it.start_req) begin
        phase     = SEQ_RESET_LOW;
        ticks     = 0;
        bit_pos   = '0;
        byte_pos  = '0;
        shift_reg = '0;
      end
      exp.busy_res = (phase != SEQ_IDLE);
      case (phase)
        SEQ_RESET_LOW: begin
          exp.drive_low = 1'b1;
          if (ticks + 1 >= at_least_one(reset_low)) begin
            phase = SEQ_PRESENCE;
            ticks = 0;
          end else ticks++;
        end
        SEQ_PRESENCE: begin
          if (ticks >= presence_wait) begin
            last_status = it.line_in;
            phase = SEQ_RESET_TAIL;
            ticks = 0;
          end else ticks++;
        end
        SEQ_RESET_TAIL: begin
          if (ticks + 1 >= at_least_one(reset_tail)) begin
            ticks = 0;
            bit_pos = '0;
            if (last_status) begin
              phase = SEQ_IDLE;
              exp.done_res = 1'b1;
            end else begin
              phase = (cmd_gap == 0) ? SEQ_WRITE : SEQ_GAP;
            end
          end else ticks++;
        end
        SEQ_GAP: begin
          if (ticks + 1 >= cmd_gap) begin
            phase = SEQ_WRITE;
            ticks = 0;
            bit_pos = '0;
          end else ticks++;
        end
        SEQ_WRITE: begin
          cmd = command_seq[byte_pos[1:0]];
          if (ticks < slot) exp.drive_low = cmd[bit_pos] ? (ticks == 0) : 1'b1;
          if (ticks >= slot) begin
            ticks = 0;
            if (bit_pos == 3'd7) begin
              bit_pos = '0;
              byte_pos = byte_pos + 3'd1;
              if (byte_pos == 3'd2) phase = SEQ_CONVERT;
              else if (byte_pos >= 3'd4) phase = SEQ_READ;
            end else bit_pos++;
          end else ticks++;
        end
        SEQ_CONVERT: begin
          if (ticks + 1 >= at_least_one(conv_wait)) begin
            phase = SEQ_RESET_LOW;
            ticks = 0;
          end else ticks++;
        end
        SEQ_READ: begin
          exp.drive_low = (ticks == 0);
          if (ticks == 2) shift_reg[bit_pos] = shift_reg[bit_pos] | it.line_in;
          if (ticks >= slot) begin
            ticks = 0;
            if (bit_pos == 3'd7) begin
              bit_pos = '0;
              if (byte_pos == 3'd4) begin
                lsb_byte = shift_reg;
                shift_reg = '0;
                byte_pos = 3'd5;
              end else begin
                reading = {shift_reg, lsb_byte};
                last_status = 1'b0;
                phase = SEQ_IDLE;
                exp.done_res = 1'b1;
              end
            end else bit_pos++;
          end else ticks++;
        end
        default: ticks = 0;
      endcase
      exp.status = last_status;
      exp.temperature_raw = reading;
      expected_results.push_back(exp);
    endfunction

    function void check_result(result_t got);
      result_t exp;
      if (expected_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("Unexpected result: drv=%0b busy=%0b done=%0b st=%0b raw=%04h",
                   got.drive_low, got.busy_res, got.done_res, got.status,
                   got.temperature_raw);
        return;
      end
      exp = expected_results.pop_front();
      if (got.drive_low !== exp.drive_low || got.busy_res !== exp.busy_res ||
          got.done_res !== exp.done_res || got.status !== exp.status ||
          got.temperature_raw !== exp.temperature_raw) begin
        errors++;
        if (errors <= 10)
          $display("Mismatch: exp drv/busy/done/st/raw %0b%0b%0b%0b %04h, got %0b%0b%0b%0b %04h",
                   exp.drive_low, exp.busy_res, exp.done_res, exp.status,
                   exp.temperature_raw, got.drive_low, got.busy_res, got.done_res,
                   got.status, got.temperature_raw);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned ticks_sent = 0;
  int unsigned quiet_cycles = 0;
  temp_read_scoreboard sb;

  owr_in_if  in_if();
  owr_out_if out_if();
  owr_cfg_if cfg_if();

  one_wire_temperature_reader uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if),
    .cfg_ch (cfg_if)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1)
      sb.check_result(result_t'{out_if.drive_low, out_if.busy_res, out_if.done_res,
                                out_if.status, out_if.temperature_raw});
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic drive_tick(item_t it);
    in_if.valid     <= 1'b1;
    in_if.start_req <= it.start_req;
    in_if.line_in   <= it.line_in;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    sb.note_tick(it);
    ticks_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.idx   <= idx;
    cfg_if.wdata <= data;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    sb.write_reg(idx, data);
    cfg_if.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_timing(int unsigned rlow, int unsigned pwait, int unsigned rtail,
                            int unsigned slot, int unsigned gap, int unsigned conv);
    wait_results();
    repeat (4) @(posedge clk);
    write_reg(REG_RESET_LOW, CFG_DATA_W'(rlow));
    write_reg(REG_PRESENCE_WAIT, CFG_DATA_W'(pwait));
    write_reg(REG_RESET_TAIL, CFG_DATA_W'(rtail));
    write_reg(REG_SLOT, CFG_DATA_W'(slot));
    write_reg(REG_CMD_GAP, CFG_DATA_W'(gap));
    write_reg(REG_CONV_WAIT, CFG_DATA_W'(conv));
  endtask

  // Presence and read-bit levels are steered by the predicted bus phase, so
  // the requested scenario is played out with random content elsewhere.
  task automatic run_measurement(bit present_first, bit present_second,
                                 read_pattern_t read_mode, bit pause);
    item_t       it;
    int unsigned n;
    int unsigned pause_at;
    n = 0;
    pause_at = $urandom_range(5, 80);
    repeat ($urandom_range(0, 3)) begin
      it.start_req = 1'b0;
      it.line_in   = 1'($urandom_range(1));
      drive_tick(it);
    end
    do begin
      it.start_req = (sb.phase == SEQ_IDLE) ? 1'b1 : 1'($urandom_range(1));
      it.line_in   = 1'($urandom_range(1));
      if (sb.phase == SEQ_PRESENCE && sb.ticks >= sb.presence_wait)
        it.line_in = (sb.byte_pos == 3'd0) ? !present_first : !present_second;
      else if (sb.phase == SEQ_READ && sb.ticks == 2 && read_mode != READ_RANDOM)
        it.line_in = (read_mode == READ_ONES);
      drive_tick(it);
      n++;
      if (pause && n == pause_at) wait_results();
    end while (sb.phase != SEQ_IDLE);
  endtask

  initial begin
    sb = new();
    send_idle_pct   = 17;
    recv_idle_pct   = 62;
    rst_n           = 1'b0;
    in_if.valid     = 1'b0;
    in_if.start_req = 1'b0;
    in_if.line_in   = 1'b0;
    out_if.ready    = 1'b0;
    cfg_if.valid    = 1'b0;
    cfg_if.idx      = '0;
    cfg_if.wdata    = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    set_timing(0, 0, 0, 0, 0, 0);
    run_measurement(1'b1, 1'b1, READ_ONES, 1'b1);
    set_timing(1, 1, 1, 1, 1, 1);
    run_measurement(1'b1, 1'b1, READ_ZEROS, 1'b0);
    wait_results();
    repeat (4) @(posedge clk);
    write_reg(REG_RESET_LOW, 20'hFFC02);
    write_reg(REG_SLOT, 20'hFFF03);
    write_reg(REG_SPARE_6, 20'h00000);
    write_reg(REG_SPARE_7, 20'hFFFFF);
    run_measurement(1'b1, 1'b0, READ_RANDOM, 1'b0);

    while (ticks_sent < TOTAL_TICKS) begin
      if (ticks_sent < TOTAL_TICKS / 3) begin
        send_idle_pct = 17;
        recv_idle_pct = 62;
      end else if (ticks_sent < 2 * TOTAL_TICKS / 3) begin
        send_idle_pct = 62;
        recv_idle_pct = 17;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      set_timing($urandom_range(0, 6), $urandom_range(0, 5), $urandom_range(0, 6),
                 $urandom_range(0, 3), $urandom_range(0, 5), $urandom_range(0, 8));
      run_measurement($urandom_range(9) != 0, $urandom_range(9) != 0, READ_RANDOM,
                      $urandom_range(2) == 0);
    end

    wait_results();
    repeat (10) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
